// ===== hw/rtl/pimfm_pkg.sv =====
// Shared types and constants of the pulse interval median flow meter.
package pimfm_pkg;

    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 24;
    localparam int COUNT_W    = 4;
    localparam int WINDOW_DEF = 10;

    // Quotient of 1e6 in Q16.16 over a 32-bit interval fits in 36 bits; DIV_W gives 37
    localparam int DIV_W = 37;

    localparam logic [DIV_W-1:0]  ONE_MHZ_Q16 = 37'd65536000000;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 24'd145636;

    // Per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // copy own interval into the circulating word, clear ranks
        logic shift;  // compare against circulating word, pass it on
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/pimfm_cell.sv =====
// One interval slot of the ring plus its rank counters.
module pimfm_cell #(
    parameter int WINDOW = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [pimfm_pkg::DATA_W-1:0] wr_data,
    input  pimfm_pkg::cell_ctrl_t        ctrl,
    input  logic [pimfm_pkg::DATA_W-1:0] pass_in,
    output logic [pimfm_pkg::DATA_W-1:0] pass_out,
    output logic [pimfm_pkg::DATA_W-1:0] value,
    output logic [$clog2(WINDOW+1)-1:0]  lt_count,
    output logic [$clog2(WINDOW+1)-1:0]  le_count
);
    import pimfm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] pass_reg;
    logic [CNT_W-1:0]  lt_reg;
    logic [CNT_W-1:0]  le_reg;
    logic              pass_live;

    // ring slot itself: cleared at reset, zero means empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (wr_en)
        begin
            val_reg <= wr_data;
        end
    end

    assign pass_live = (pass_reg != '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pass_reg <= val_reg;
            lt_reg   <= '0;
            le_reg   <= '0;
        end
        else if (ctrl.shift)
        begin
            pass_reg <= pass_in;
            if (pass_live && (pass_reg < val_reg))
            begin
                lt_reg <= lt_reg + CNT_W'(1);
            end
            if (pass_live && (pass_reg <= val_reg))
            begin
                le_reg <= le_reg + CNT_W'(1);
            end
        end
    end

    assign pass_out = pass_reg;
    assign value    = val_reg;
    assign lt_count = lt_reg;
    assign le_count = le_reg;

endmodule

// ===== hw/rtl/pimfm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pimfm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pimfm_pkg::DIV_W-1:0]  dividend,
    input  logic [pimfm_pkg::DATA_W-1:0] divisor,
    output logic                         done,
    output logic [pimfm_pkg::DIV_W-1:0]  quotient
);
    import pimfm_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              qbit;
    logic [DATA_W-1:0] rem_next;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign qbit     = (trial >= {1'b0, dsr_reg});
    assign rem_next = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend bits shift out of the top while quotient bits enter below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/pulse_interval_median_flow_meter.sv =====
// Top level: pulse interval ring, median by rank chain, frequency and flow.
// Sequence: load, rank pass, select, divide, multiply, sum, then the result word;
//   divide, multiply and sum are skipped when the ring holds no interval.
// Input: a new word is taken only when idle, after the last result is loaded; the rank
//   pass, the 37-step divider and a stalled result all hold off the next word.
// Reset (rst_n, async low): ring cleared, pulse counter and flags zero, flow_gain 145636 (Q8.16).
module pulse_interval_median_flow_meter #(
    parameter int WINDOW = pimfm_pkg::WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // pulse edge words
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pimfm_pkg::DATA_W-1:0]  time_us,
    // result words
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pimfm_pkg::DATA_W-1:0]  median_interval_us,
    output logic [pimfm_pkg::DATA_W-1:0]  frequency_q16,
    output logic [pimfm_pkg::DATA_W-1:0]  flow_rate_q16,
    output logic [pimfm_pkg::DATA_W-1:0]  pulse_total,
    output logic [pimfm_pkg::COUNT_W-1:0] interval_count,
    // gain register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pimfm_pkg::GAIN_W-1:0]  flow_gain
);
    import pimfm_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_RANK  = 9'b000000100,
        S_SEL   = 9'b000001000,
        S_START = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_SUM   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [DATA_W-1:0] prev_time_reg;
    logic              seen_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [DATA_W-1:0] pulse_cnt_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [SLOT_W-1:0] rank_step_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              in_accept;
    logic [DATA_W-1:0] interval;
    cell_ctrl_t        cell_ctrl;

    logic [DATA_W-1:0] cell_val  [WINDOW];
    logic [DATA_W-1:0] cell_pass [WINDOW];
    logic [CNT_W-1:0]  cell_lt   [WINDOW];
    logic [CNT_W-1:0]  cell_le   [WINDOW];

    logic [CNT_W-1:0]  live_count;
    logic [CNT_W-1:0]  mid_rank;
    logic [DATA_W-1:0] median_sel;

    logic [DATA_W-1:0] median_reg;
    logic [DIV_W-1:0]  freq_raw_reg;
    logic [55:0]       prod_lo_reg;
    logic [28:0]       prod_hi_reg;
    logic [DATA_W-1:0] freq_res_reg;
    logic [DATA_W-1:0] flow_res_reg;

    logic              div_start;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [DIV_W-1:0]  dividend;

    logic [61:0]       flow_sum;
    logic [45:0]       flow_full;
    logic [31:0]       count_wide;

    logic              out_valid_reg;
    logic              out_load;
    logic [DATA_W-1:0] out_median_reg;
    logic [DATA_W-1:0] out_freq_reg;
    logic [DATA_W-1:0] out_flow_reg;
    logic [DATA_W-1:0] out_total_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // output register frees up on take, so the next result can land
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    assign interval  = time_us - prev_time_reg;

    // ---------------------------------------------------------------
    // Pulse bookkeeping and gain register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            seen_reg      <= 1'b0;
            slot_reg      <= '0;
            pulse_cnt_reg <= '0;
            gain_reg      <= GAIN_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                gain_reg <= flow_gain;
            end
            if (in_accept)
            begin
                prev_time_reg <= time_us;
                seen_reg      <= 1'b1;
                pulse_cnt_reg <= pulse_cnt_reg + 32'd1;
                // first pulse after reset stores no interval
                if (seen_reg)
                begin
                    if (slot_reg == SLOT_W'(WINDOW - 1))
                    begin
                        slot_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Cell chain: ring slots; circulating word goes around once for ranks
    // ---------------------------------------------------------------
    assign cell_ctrl.load  = (state_reg == S_LOAD);
    assign cell_ctrl.shift = (state_reg == S_RANK);

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        pimfm_cell #(
            .WINDOW (WINDOW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (in_accept && seen_reg && (slot_reg == SLOT_W'(i))),
            .wr_data  (interval),
            .ctrl     (cell_ctrl),
            .pass_in  (cell_pass[(i + WINDOW - 1) % WINDOW]),
            .pass_out (cell_pass[i]),
            .value    (cell_val[i]),
            .lt_count (cell_lt[i]),
            .le_count (cell_le[i])
        );
    end

    // number of nonzero slots
    always_comb
    begin
        live_count = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            live_count = live_count + CNT_W'(cell_val[i] != '0);
        end
    end

    // upper median sits at sorted position count/2; any cell whose
    // [lt, le) range covers it holds that value (ties hold equal values)
    assign mid_rank = count_reg >> 1;

    always_comb
    begin
        median_sel = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if ((cell_val[i] != '0) && (cell_lt[i] <= mid_rank) &&
                (mid_rank < cell_le[i]))
            begin
                median_sel = median_sel | cell_val[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // Frequency divide and flow multiply
    // ---------------------------------------------------------------
    assign div_start = (state_reg == S_START);
    assign dividend  = ONE_MHZ_Q16 + DIV_W'(median_reg >> 1);

    pimfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (median_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // F * gain split into a 32-bit low part and a 5-bit high part
    assign flow_sum  = {1'b0, prod_hi_reg, 32'd0} + 62'(prod_lo_reg) + 62'd32768;
    assign flow_full = flow_sum[61:16];

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_LOAD:
            begin
                count_reg     <= live_count;
                rank_step_reg <= '0;
            end
            S_RANK:
            begin
                rank_step_reg <= rank_step_reg + SLOT_W'(1);
            end
            S_SEL:
            begin
                median_reg   <= median_sel;
                freq_res_reg <= '0;
                flow_res_reg <= '0;
            end
            S_DIV:
            begin
                freq_raw_reg <= div_quo;
            end
            S_MUL:
            begin
                prod_lo_reg <= freq_raw_reg[31:0] * gain_reg;
                prod_hi_reg <= freq_raw_reg[DIV_W-1:32] * gain_reg;
            end
            S_SUM:
            begin
                freq_res_reg <= (|freq_raw_reg[DIV_W-1:32]) ? '1 : freq_raw_reg[31:0];
                flow_res_reg <= (|flow_full[45:32]) ? '1 : flow_full[31:0];
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_LOAD;
            S_LOAD:  state_next = S_RANK;
            S_RANK:  if (rank_step_reg == SLOT_W'(WINDOW - 1)) state_next = S_SEL;
            S_SEL:   state_next = (count_reg == '0) ? S_OUT : S_START;
            S_START: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_MUL;
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    assign count_wide = 32'(count_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_median_reg <= median_reg;
            out_freq_reg   <= freq_res_reg;
            out_flow_reg   <= flow_res_reg;
            out_total_reg  <= pulse_cnt_reg;
            out_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    assign out_valid          = out_valid_reg;
    assign median_interval_us = out_median_reg;
    assign frequency_q16      = out_freq_reg;
    assign flow_rate_q16      = out_flow_reg;
    assign pulse_total        = out_total_reg;
    assign interval_count     = out_count_reg;

endmodule

// ===== test/pulse_interval_median_flow_meter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pulse interval median flow meter.
module pulse_interval_median_flow_meter_tb;
    import pimfm_pkg::*;

    // The block is built with its default window; the predictor uses the same depth.
    localparam int WINDOW        = WINDOW_DEF;
    localparam int GAP_MAX       = 10;   // longest idle draw on either side
    localparam int SETTLE_CYCLES = 8;    // quiet cycles before a gain write or a hold ends
    localparam int TAIL_CYCLES   = WINDOW + 60;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASES        = 8;
    localparam int PHASE_PULSES  = 60;

    localparam logic [63:0]       MHZ_Q16       = 64'd65536000000; // 1e6 in Q16.16
    localparam logic [63:0]       SAT32         = 64'hFFFF_FFFF;
    localparam logic [GAIN_W-1:0] GAIN_AT_RESET = 24'd145636;
    localparam logic [GAIN_W-1:0] GAIN_MAX      = 24'hFF_FFFF;

    // What the sender does with one entry of its work list
    typedef enum logic [1:0] {
        ITEM_PULSE,   // present a pulse word
        ITEM_GAIN,    // wait for an idle block, then write flow_gain
        ITEM_HOLD     // wait until every predicted reading has come back
    } item_kind_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [DATA_W-1:0] value;
    } stim_item_t;

    // One meter reading as the block reports it
    typedef struct packed {
        logic [DATA_W-1:0]  median;
        logic [DATA_W-1:0]  freq;
        logic [DATA_W-1:0]  flow;
        logic [DATA_W-1:0]  total;
        logic [COUNT_W-1:0] count;
    } meter_reading_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [DATA_W-1:0]   time_us   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DATA_W-1:0]   median_interval_us;
    logic [DATA_W-1:0]   frequency_q16;
    logic [DATA_W-1:0]   flow_rate_q16;
    logic [DATA_W-1:0]   pulse_total;
    logic [COUNT_W-1:0]  interval_count;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [GAIN_W-1:0]   flow_gain = '0;

    stim_item_t     pending[$];        // work list for the sender
    meter_reading_t readings_due[$];   // predicted readings, oldest first

    // Predictor state: a software copy of the meter
    logic [DATA_W-1:0] last_stamp;
    bit                stamp_seen;
    logic [DATA_W-1:0] interval_slots[WINDOW];
    int                next_slot;
    logic [DATA_W-1:0] pulses_seen;
    logic [GAIN_W-1:0] gain_model;

    int unsigned error_count  = 0;
    int unsigned pulses_sent  = 0;
    int unsigned gain_writes  = 0;
    int unsigned readings_ok  = 0;
    int unsigned empty_window = 0;
    int unsigned saturated    = 0;

    pulse_interval_median_flow_meter dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .time_us            (time_us),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .median_interval_us (median_interval_us),
        .frequency_q16      (frequency_q16),
        .flow_rate_q16      (flow_rate_q16),
        .pulse_total        (pulse_total),
        .interval_count     (interval_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .flow_gain          (flow_gain)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a reading.
    initial
    begin
        #5_000_000;
        $display("pulse_interval_median_flow_meter_tb: done, errors");
        $finish;
    end

    task automatic queue_item(input item_kind_t kind, input logic [DATA_W-1:0] value);
        stim_item_t it;
        it.kind  = kind;
        it.value = value;
        pending.push_back(it);
    endtask

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Advance the meter copy by one pulse and queue the reading it must produce.
    // The first pulse only latches its timestamp; later ones store the wrapping
    // difference, and a zero difference simply empties that slot.
    task automatic predict_reading(input logic [DATA_W-1:0] stamp);
        logic [DATA_W-1:0] ordered[WINDOW];
        logic [DATA_W-1:0] v;
        logic [63:0]       median;
        logic [63:0]       freq_raw;
        logic [63:0]       flow_raw;
        meter_reading_t    r;
        int                n;
        int                i;
        int                j;
        if (stamp_seen)
        begin
            interval_slots[next_slot] = stamp - last_stamp;
            next_slot = (next_slot + 1) % WINDOW;
        end
        last_stamp  = stamp;
        stamp_seen  = 1'b1;
        pulses_seen = pulses_seen + 1'b1;

        // insertion sort of the occupied slots
        n = 0;
        for (i = 0; i < WINDOW; i++)
        begin
            v = interval_slots[i];
            if (v != '0)
            begin
                j = n;
                while (j > 0 && ordered[j-1] > v)
                begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = v;
                n++;
            end
        end

        r = '0;
        if (n > 0)
        begin
            median   = 64'(ordered[n/2]);          // upper median
            freq_raw = (MHZ_Q16 + (median >> 1)) / median;
            // flow uses the unsaturated frequency; product stays below 2^61
            flow_raw = (freq_raw * 64'(gain_model) + 64'h8000) >> 16;
            r.median = median[DATA_W-1:0];
            r.freq   = (freq_raw > SAT32) ? '1 : freq_raw[DATA_W-1:0];
            r.flow   = (flow_raw > SAT32) ? '1 : flow_raw[DATA_W-1:0];
        end
        r.total = pulses_seen;
        r.count = COUNT_W'(n);
        readings_due.push_back(r);
    endtask

    // Sender: pulse words and gain writes from the work list. Predictions are
    // made at the accepting edge so the gain in force is always the one the
    // block used. Gain writes and holds wait until all readings are back.
    always @(posedge clk or negedge rst_n)
    begin : sender
        int                gap_left;
        int                settle;
        bit                calm;
        int                i;
        logic              nxt_valid;
        logic              nxt_cfg;
        logic [DATA_W-1:0] nxt_time;
        logic [GAIN_W-1:0] nxt_gain;
        stim_item_t        head;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            time_us   <= '0;
            flow_gain <= '0;
            gap_left    = 0;
            settle      = 0;
            calm        = 1'b0;
            last_stamp  = '0;
            stamp_seen  = 1'b0;
            next_slot   = 0;
            pulses_seen = '0;
            gain_model  = GAIN_AT_RESET;
            for (i = 0; i < WINDOW; i++)
                interval_slots[i] = '0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_cfg   = cfg_valid;
            nxt_time  = time_us;
            nxt_gain  = flow_gain;
            if (in_valid && !in_stall)
            begin
                predict_reading(time_us);
                nxt_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                gain_model = flow_gain;
                gain_writes++;
                nxt_cfg = 1'b0;
            end
            if (!nxt_valid && !nxt_cfg && pending.size() != 0)
            begin
                head = pending[0];
                if (head.kind == ITEM_PULSE)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        head      = pending.pop_front();
                        nxt_valid = 1'b1;
                        nxt_time  = head.value;
                        pulses_sent++;
                        // stretches without idling now and then
                        if ($urandom_range(0, 39) == 0)
                            calm = !calm;
                        gap_left = calm ? 0 : $urandom_range(0, GAP_MAX);
                    end
                end
                else if (readings_due.size() != 0)
                    settle = 0;
                else if (settle < SETTLE_CYCLES)
                    settle++;
                else
                begin
                    settle = 0;
                    head   = pending.pop_front();
                    if (head.kind == ITEM_GAIN)
                    begin
                        nxt_cfg  = 1'b1;
                        nxt_gain = head.value[GAIN_W-1:0];
                    end
                end
            end
            in_valid  <= nxt_valid;
            cfg_valid <= nxt_cfg;
            time_us   <= nxt_time;
            flow_gain <= nxt_gain;
        end
    end

    // Receiver: random stall per reading, counted down mostly while a reading
    // is offered so that stalls really hold results back.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int             stall_left;
        bit             calm;
        meter_reading_t got;
        meter_reading_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            calm       = 1'b1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.median = median_interval_us;
                got.freq   = frequency_q16;
                got.flow   = flow_rate_q16;
                got.total  = pulse_total;
                got.count  = interval_count;
                if (readings_due.size() == 0)
                    log_error($sformatf("reading with none pending: total %0d", got.total));
                else
                begin
                    want = readings_due.pop_front();
                    if (got !== want)
                        log_error($sformatf({"reading %0d: expected med %0d frq %h flw %h ",
                            "cnt %0d, got med %0d frq %h flw %h tot %0d cnt %0d"},
                            want.total, want.median, want.freq, want.flow, want.count,
                            got.median, got.freq, got.flow, got.total, got.count));
                    else
                        readings_ok++;
                    if (want.count == '0)
                        empty_window++;
                    if (want.freq == '1)
                        saturated++;
                end
                if ($urandom_range(0, 29) == 0)
                    calm = !calm;
                stall_left = calm ? 0 : $urandom_range(0, GAP_MAX);
            end
            else if (stall_left > 0 && (out_valid || $urandom_range(0, 7) == 0))
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    initial
    begin : stimulus
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] jit;
        int                p;
        int                k;
        int                r;

        // Directed: first pulse, repeated stamp, one-microsecond interval
        // (saturates frequency and flow), wrap of the timestamp and the
        // largest possible interval, all under the reset gain.
        queue_item(ITEM_PULSE, 32'd0);
        queue_item(ITEM_PULSE, 32'd0);
        queue_item(ITEM_PULSE, 32'd1);
        queue_item(ITEM_PULSE, 32'd1001);
        queue_item(ITEM_PULSE, 32'd2000);
        queue_item(ITEM_PULSE, 32'hFFFF_FFF0);
        queue_item(ITEM_PULSE, 32'h0000_0010);
        queue_item(ITEM_PULSE, 32'h0000_000F);
        // gain extremes
        queue_item(ITEM_GAIN, 32'(GAIN_MAX));
        queue_item(ITEM_PULSE, 32'h0000_0010);
        queue_item(ITEM_PULSE, 32'h0000_0012);
        queue_item(ITEM_PULSE, 32'h0000_0400);
        queue_item(ITEM_GAIN, 32'd0);
        queue_item(ITEM_PULSE, 32'h0000_0800);
        queue_item(ITEM_PULSE, 32'h0000_0C01);
        queue_item(ITEM_GAIN, 32'(GAIN_AT_RESET));
        // steady train that wraps the interval ring
        stamp = 32'h0000_1000;
        for (k = 0; k < 12; k++)
        begin
            stamp = stamp + 32'd1000 + k;
            queue_item(ITEM_PULSE, stamp);
        end

        // Random phases: each with its own gain and a typical pulse period,
        // mostly regular trains with jitter, plus repeats, jumps and bursts.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: queue_item(ITEM_GAIN, 32'd0);
                1: queue_item(ITEM_GAIN, 32'(GAIN_MAX));
                4: queue_item(ITEM_GAIN, 32'(GAIN_AT_RESET));
                default: queue_item(ITEM_GAIN, $urandom_range(0, GAIN_MAX));
            endcase
            case ($urandom_range(0, 3))
                0: period = $urandom_range(1, 40);
                1: period = $urandom_range(500, 60000);
                2: period = $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
                default: period = $urandom_range(60000, 32'h00FF_FFFF);
            endcase
            jit = period >> 3;
            for (k = 0; k < PHASE_PULSES; k++)
            begin
                // sender holds off until the block has caught up
                if (p == 3 && k == PHASE_PULSES / 2)
                    queue_item(ITEM_HOLD, '0);
                r = $urandom_range(0, 99);
                if (r < 78)
                    stamp = stamp + period - jit + $urandom_range(0, 2 * jit);
                else if (r < 86)
                    stamp = stamp;                // same stamp: zero interval
                else if (r < 94)
                    stamp = $urandom;             // arbitrary jump
                else
                    stamp = stamp + $urandom_range(1, 3);
                queue_item(ITEM_PULSE, stamp);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid || cfg_valid || readings_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d pulse words and %0d gain writes; %0d readings matched.",
            pulses_sent, gain_writes, readings_ok);
        $display("Readings with an empty window: %0d, with saturated frequency: %0d.",
            empty_window, saturated);
        if (error_count == 0)
            $display("pulse_interval_median_flow_meter_tb: done, clean");
        else
            $display("pulse_interval_median_flow_meter_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pimfm_pkg.sv
hw/rtl/pimfm_cell.sv
hw/rtl/pimfm_div.sv
hw/rtl/pulse_interval_median_flow_meter.sv
test/pulse_interval_median_flow_meter_tb.sv
